@@ rtl/avsfg_pkg.sv @@
// ----------------------------------------------------------------------------
// avsfg_pkg
// Shared types and constants for the video frame gate.
// ----------------------------------------------------------------------------
package avsfg_pkg;

  localparam int unsigned TimeW     = 64;
  localparam int unsigned LeadW     = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned NumCounts = 5;
  localparam int unsigned OpW       = 2;
  localparam int unsigned DispW     = 3;

  localparam logic [LeadW-1:0] LeadReset = LeadW'(10000000);

  typedef enum logic [OpW-1:0] {
    OP_START     = 2'd0,
    OP_AUDIO_END = 2'd1,
    OP_VIDEO     = 2'd2
  } op_e;

  // Disposition codes double as counter slots.
  typedef enum logic [DispW-1:0] {
    DISP_ACCEPTED      = 3'd0,
    DISP_BEFORE_ANCHOR = 3'd1,
    DISP_BAD_DURATION  = 3'd2,
    DISP_BACKWARD      = 3'd3,
    DISP_TOO_FAR_AHEAD = 3'd4
  } disp_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TimeW-1:0] ts;
    logic [TimeW-1:0] dur;
  } item_t;

  typedef struct packed {
    logic [NumCounts-1:0][CountW-1:0] cnt;
    logic [TimeW-1:0]                 dur;
    logic [TimeW-1:0]                 ptime;
    disp_e                            disp;
  } result_t;

endpackage

@@ rtl/avsfg_in_stage.sv @@
// ----------------------------------------------------------------------------
// avsfg_in_stage
// Input register: holds one beat until the decision stage takes it.
// ----------------------------------------------------------------------------
module avsfg_in_stage
  import avsfg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/avsfg_core.sv @@
// ----------------------------------------------------------------------------
// avsfg_core
// Timeline state, lead register and the per-frame drop decision.
// ----------------------------------------------------------------------------
module avsfg_core
  import avsfg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LeadW-1:0] cfg_data_i,
  input  logic             fire_i,
  input  item_t            item_i,
  output result_t          result_o
);

  logic                             started_q, started_d;
  logic                             any_q, any_d;
  logic [TimeW-1:0]                 anchor_q, anchor_d;
  logic [TimeW-1:0]                 end_q, end_d;
  logic [TimeW-1:0]                 last_q, last_d;
  logic [LeadW-1:0]                 lead_q;
  logic [NumCounts-1:0][CountW-1:0] cnt_q, cnt_d;
  logic [TimeW:0]                   lead_sum;
  logic [TimeW-1:0]                 limit;
  disp_e                            disp;
  logic [TimeW-1:0]                 ptime;

  always_comb begin
    lead_sum = {1'b0, end_q} + {(TimeW - LeadW + 1)'(0), lead_q};
    limit    = lead_sum[TimeW] ? '1 : lead_sum[TimeW-1:0];

    disp  = DISP_ACCEPTED;
    ptime = '0;
    if (!started_q || item_i.ts < anchor_q) begin
      disp = DISP_BEFORE_ANCHOR;
    end else if (item_i.dur == '0) begin
      disp = DISP_BAD_DURATION;
    end else if (any_q && item_i.ts <= last_q) begin
      disp = DISP_BACKWARD;
    end else if (item_i.ts > limit) begin
      disp = DISP_TOO_FAR_AHEAD;
    end else begin
      ptime = item_i.ts - anchor_q;
    end

    started_d = started_q;
    any_d     = any_q;
    anchor_d  = anchor_q;
    end_d     = end_q;
    last_d    = last_q;
    cnt_d     = cnt_q;

    for (int i = 0; i < NumCounts; i++) begin
      if (disp == disp_e'(DispW'(i)) && cnt_q[i] != '1) begin
        cnt_d[i] = cnt_q[i] + CountW'(1);
      end
    end

    case (item_i.op)
      OP_START: begin
        if (!started_q) begin
          started_d = 1'b1;
          anchor_d  = item_i.ts;
          end_d     = item_i.ts;
        end
      end
      OP_AUDIO_END: begin
        if (started_q && item_i.ts > end_q) begin
          end_d = item_i.ts;
        end
      end
      OP_VIDEO: begin
        if (disp == DISP_ACCEPTED) begin
          last_d = item_i.ts;
          any_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      any_q     <= 1'b0;
      anchor_q  <= '0;
      end_q     <= '0;
      last_q    <= '0;
      cnt_q     <= '0;
      lead_q    <= LeadReset;
    end else begin
      if (fire_i) begin
        started_q <= started_d;
        any_q     <= any_d;
        anchor_q  <= anchor_d;
        end_q     <= end_d;
        last_q    <= last_d;
        if (item_i.op == OP_VIDEO) begin
          cnt_q <= cnt_d;
        end
      end
      if (cfg_we_i) begin
        lead_q <= cfg_data_i;
      end
    end
  end

  assign result_o.disp  = disp;
  assign result_o.ptime = ptime;
  assign result_o.dur   = item_i.dur;
  assign result_o.cnt   = cnt_d;

endmodule

@@ rtl/avsfg_out_stage.sv @@
// ----------------------------------------------------------------------------
// avsfg_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module avsfg_out_stage
  import avsfg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign space_o = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ rtl/av_sync_video_frame_gate.sv @@
// ----------------------------------------------------------------------------
// av_sync_video_frame_gate
// Gates video frame timestamps against an audio timeline.
// ----------------------------------------------------------------------------
// Slave stream: tuser carries the op (start, audio end, video frame), tdata
// the timestamp and the frame duration. Start and audio-end beats update the
// timeline and return nothing; each video beat returns one result beat on the
// master stream with its disposition in tuser and presentation time,
// duration and the five saturating event counters in tdata.
// A video beat taken on the slave side passes the input register, then the
// result register, to the master side. Throughput: one beat per cycle while
// no video beat waits on the result register, set by the single decision
// stage between the two registers. The slave side accepts while a result
// waits; when the receiver stalls, a video beat holds in the input register
// until the result register frees, and the beats behind it wait as well.
// The cfg channel writes max_video_lead and is always ready; write it only
// while the block is idle.
// Reset clears the timeline, the counters and both valid flags, and loads
// max_video_lead with 10000000.
// ----------------------------------------------------------------------------
module av_sync_video_frame_gate
  import avsfg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [127:0]     s_axis_tdata,  // timestamp, frame_duration
  input  logic [OpW-1:0]   s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // presentation_time, duration_echo, count_accepted, count_before_anchor,
  // count_bad_duration, count_backward, count_too_far_ahead
  output logic [287:0]     m_axis_tdata,
  output logic [DispW-1:0] m_axis_tuser,  // disposition
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LeadW-1:0] cfg_data_i
);

  item_t   in_item, s1_item;
  logic    s1_valid, s1_take, out_space, is_video;
  result_t core_res, out_res;

  assign in_item.op  = s_axis_tuser;
  assign in_item.ts  = s_axis_tdata[63:0];
  assign in_item.dur = s_axis_tdata[127:64];

  assign is_video = (s1_item.op == OP_VIDEO);
  assign s1_take  = s1_valid && (!is_video || out_space);

  avsfg_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (s1_take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  assign cfg_ready_o = 1'b1;

  avsfg_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (s1_take),
    .item_i     (s1_item),
    .result_o   (core_res)
  );

  avsfg_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_take && is_video),
    .result_i    (core_res),
    .space_o     (out_space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_res)
  );

  assign m_axis_tdata = {out_res.cnt, out_res.dur, out_res.ptime};
  assign m_axis_tuser = out_res.disp;

endmodule

@@ rtl/avsfg_checker.sv @@
// ----------------------------------------------------------------------------
// avsfg_checker
// Port-level checks on the result stream of the video frame gate.
// ----------------------------------------------------------------------------
module avsfg_checker
  import avsfg_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [287:0]     m_axis_tdata,
  input logic [DispW-1:0] m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_disp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= DISP_TOO_FAR_AHEAD)
    else $error("disposition out of range");

  a_drop_ptime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != DISP_ACCEPTED |-> m_axis_tdata[63:0] == '0)
    else $error("dropped frame with nonzero presentation time");

  a_zero_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[127:64] == '0 |->
      m_axis_tuser == DISP_BAD_DURATION || m_axis_tuser == DISP_BEFORE_ANCHOR)
    else $error("zero duration frame not dropped");

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind av_sync_video_frame_gate avsfg_checker u_avsfg_checker (.*);

@@ tb/gate_verdict_checker.sv @@
// ----------------------------------------------------------------------------
// gate_verdict_checker
// Watches the slave, master and cfg channels of the video frame gate, keeps
// its own copy of the audio timeline and event counters, predicts the verdict
// of every video beat and compares each result beat field by field.
// ----------------------------------------------------------------------------
module gate_verdict_checker
  import avsfg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [127:0]         s_axis_tdata_i,  // timestamp, frame_duration
  input  logic [OpW-1:0]       s_axis_tuser_i,  // op
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  // presentation_time, duration_echo, count_accepted, count_before_anchor,
  // count_bad_duration, count_backward, count_too_far_ahead
  input  logic [287:0]         m_axis_tdata_i,
  input  logic [DispW-1:0]     m_axis_tuser_i,  // disposition
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [LeadW-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   verdicts_o,
  output logic [NumCounts-1:0] disp_seen_o
);

  string count_names [NumCounts] = '{"count_accepted", "count_before_anchor",
                                     "count_bad_duration", "count_backward",
                                     "count_too_far_ahead"};

  logic [LeadW-1:0]                 max_lead;
  logic                             started;
  logic                             any_accepted;
  logic [TimeW-1:0]                 anchor_ts;
  logic [TimeW-1:0]                 audio_end;
  logic [TimeW-1:0]                 last_frame_ts;
  logic [NumCounts-1:0][CountW-1:0] event_counts;
  result_t                          verdicts_due [$];
  int                               failures;
  int                               verdicts_seen;
  logic [NumCounts-1:0]             disp_seen;

  assign fail_count_o = failures;
  assign verdicts_o   = verdicts_seen;
  assign disp_seen_o  = disp_seen;

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    result_t          due;
    logic [TimeW:0]   lead_sum;
    logic [TimeW-1:0] lead_limit;
    logic [TimeW-1:0] ts;
    logic [TimeW-1:0] dur;
    disp_e            disp;
    if (!rst_ni) begin
      max_lead      = LeadReset;
      started       = 1'b0;
      any_accepted  = 1'b0;
      anchor_ts     = '0;
      audio_end     = '0;
      last_frame_ts = '0;
      event_counts  = '0;
      verdicts_due.delete();
      failures      = 0;
      verdicts_seen = 0;
      disp_seen     = '0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          $error("result beat with no video beat pending");
          failures++;
        end else begin
          due = verdicts_due.pop_front();
          disp_seen[due.disp] = 1'b1;
          if (m_axis_tuser_i !== due.disp) begin
            $error("disposition: expected %0d, got %0d", due.disp, m_axis_tuser_i);
            failures++;
          end
          if (m_axis_tdata_i[63:0] !== due.ptime) begin
            $error("presentation_time: expected %0h, got %0h", due.ptime,
                   m_axis_tdata_i[63:0]);
            failures++;
          end
          if (m_axis_tdata_i[127:64] !== due.dur) begin
            $error("duration_echo: expected %0h, got %0h", due.dur,
                   m_axis_tdata_i[127:64]);
            failures++;
          end
          for (int i = 0; i < NumCounts; i++) begin
            if (m_axis_tdata_i[128 + CountW*i +: CountW] !== due.cnt[i]) begin
              $error("%s: expected %0d, got %0d", count_names[i], due.cnt[i],
                     m_axis_tdata_i[128 + CountW*i +: CountW]);
              failures++;
            end
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) max_lead = cfg_data_i;

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        ts  = s_axis_tdata_i[63:0];
        dur = s_axis_tdata_i[127:64];
        case (s_axis_tuser_i)
          OP_START: begin
            if (!started) begin
              started   = 1'b1;
              anchor_ts = ts;
              audio_end = ts;
            end
          end
          OP_AUDIO_END: begin
            if (started && ts > audio_end) audio_end = ts;
          end
          OP_VIDEO: begin
            lead_sum   = {1'b0, audio_end} + {{(TimeW + 1 - LeadW){1'b0}}, max_lead};
            lead_limit = lead_sum[TimeW] ? '1 : lead_sum[TimeW-1:0];
            due.ptime  = '0;
            due.dur    = dur;
            if (!started || ts < anchor_ts) begin
              disp = DISP_BEFORE_ANCHOR;
            end else if (dur == '0) begin
              disp = DISP_BAD_DURATION;
            end else if (any_accepted && ts <= last_frame_ts) begin
              disp = DISP_BACKWARD;
            end else if (ts > lead_limit) begin
              disp = DISP_TOO_FAR_AHEAD;
            end else begin
              disp          = DISP_ACCEPTED;
              due.ptime     = ts - anchor_ts;
              last_frame_ts = ts;
              any_accepted  = 1'b1;
            end
            if (event_counts[disp] != '1) event_counts[disp] = event_counts[disp] + 1'b1;
            due.disp = disp;
            due.cnt  = event_counts;
            verdicts_due.push_back(due);
          end
          default: begin
          end
        endcase
      end
      pending_o <= verdicts_due.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the video frame gate with a directed opening, random timelines under
// several lead settings and a final phase with a saturated lead limit, under
// random gaps and stalls on both streams; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import avsfg_pkg::*;

  localparam int unsigned      MaxGap     = 13;
  localparam int unsigned      HoldCycles = 400;
  localparam int unsigned      WatchLimit = 3000;
  localparam int unsigned      PhaseBeats = 180;
  localparam logic [OpW-1:0]   OpUnused   = 2'd3;
  localparam logic [TimeW-1:0] TimeMax    = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [127:0]         s_axis_tdata;
  logic [OpW-1:0]       s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [287:0]         m_axis_tdata;
  logic [DispW-1:0]     m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [LeadW-1:0]     cfg_data_i;

  int                   fail_count;
  int                   pending;
  int                   verdicts;
  logic [NumCounts-1:0] disp_seen;

  int                   beats_sent;
  int                   lead_writes;
  int                   results_taken;
  int                   idle_cycles;
  int                   send_burst;
  int                   take_burst;
  logic [TimeW-1:0]     anchor_ts;
  logic [TimeW-1:0]     audio_cur;
  logic [TimeW-1:0]     frame_cur;
  logic [TimeW-1:0]     lead_cur;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  av_sync_video_frame_gate u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  gate_verdict_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .verdicts_o      (verdicts),
    .disp_seen_o     (disp_seen)
  );

  function automatic logic [TimeW-1:0] rand_dur();
    logic [TimeW-1:0] d;
    case ($urandom_range(0, 3))
      0:       d = 64'd333333;
      1:       d = 64'd417083;
      default: d = {$urandom, $urandom};
    endcase
    if (d == '0) d = 64'd1;
    return d;
  endfunction

  task automatic send_beat(input logic [OpW-1:0] op, input logic [TimeW-1:0] ts,
                           input logic [TimeW-1:0] dur);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, MaxGap);
      if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {dur, ts};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_frame(input logic [TimeW-1:0] ts, input logic [TimeW-1:0] dur);
    send_beat(OP_VIDEO, ts, dur);
    frame_cur = ts;
  endtask

  task automatic write_lead(input logic [LeadW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lead_cur = {{(TimeW - LeadW){1'b0}}, value};
    lead_writes++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_beat();
    int               pick;
    logic [TimeW-1:0] ts;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      audio_cur = audio_cur + $urandom_range(1, 400000);
      send_beat(OP_AUDIO_END, audio_cur, rand_dur());
    end else if (pick < 70) begin
      ts = frame_cur + 1 + $urandom_range(0, 300000);
      if (pick < 26 && audio_cur + lead_cur > frame_cur) ts = audio_cur + lead_cur;
      if (ts > audio_cur + lead_cur) begin
        audio_cur = ts - $urandom_range(0, lead_cur[LeadW-1:0]);
        send_beat(OP_AUDIO_END, audio_cur, rand_dur());
      end
      send_frame(ts, rand_dur());
    end else if (pick < 75) begin
      send_beat(OP_VIDEO, frame_cur + 1 + $urandom_range(0, 1000), '0);
    end else if (pick < 80) begin
      send_beat(OP_VIDEO, frame_cur, rand_dur());
    end else if (pick < 84) begin
      send_beat(OP_VIDEO, frame_cur - $urandom_range(1, 2000000), rand_dur());
    end else if (pick < 88) begin
      send_beat(OP_VIDEO, audio_cur + lead_cur + 1 + $urandom_range(0, 1000000), rand_dur());
    end else if (pick < 90) begin
      send_beat(OP_VIDEO, anchor_ts - 1 - $urandom_range(0, 1000), rand_dur());
    end else if (pick < 93) begin
      send_beat(OP_VIDEO, {$urandom, $urandom}, {$urandom, $urandom});
    end else if (pick < 95) begin
      send_beat(OpUnused, {$urandom, $urandom}, {$urandom, $urandom});
    end else if (pick < 97) begin
      send_beat(OP_START, {$urandom, $urandom}, '0);
    end else begin
      send_beat(OP_AUDIO_END, audio_cur - $urandom_range(0, 1000), '0);
    end
  endtask

  // Receiver: random stalls per beat, with two long hold-offs.
  initial begin
    int gap;
    int held_at;
    held_at       = -1;
    take_burst    = 0;
    results_taken = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ((results_taken == 60 || results_taken == 600) && held_at != results_taken) begin
        held_at = results_taken;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (take_burst > 0) begin
        gap = 0;
        take_burst--;
      end else begin
        gap = $urandom_range(0, MaxGap);
        if ($urandom_range(0, 15) == 0) take_burst = $urandom_range(10, 60);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_taken++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchLimit) begin
        $display("av_sync_video_frame_gate: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_START;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    beats_sent     = 0;
    lead_writes    = 0;
    send_burst     = 0;
    lead_cur       = {{(TimeW - LeadW){1'b0}}, LeadReset};
    anchor_ts      = 64'h0000_0150_0000_0000 | {32'h0, $urandom};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Opening: timeline not started yet, then anchor, boundaries and drops.
    send_beat(OP_VIDEO, '0, '0);
    send_beat(OP_VIDEO, TimeMax, TimeMax);
    send_beat(OP_AUDIO_END, 64'd5000, 64'd7);
    send_beat(OpUnused, TimeMax, TimeMax);
    send_beat(OP_START, anchor_ts, '0);
    send_beat(OP_START, '0, '0);
    send_beat(OP_VIDEO, anchor_ts - 1, 64'd1);
    send_beat(OP_VIDEO, anchor_ts, '0);
    send_frame(anchor_ts, 64'd1);
    send_beat(OP_VIDEO, anchor_ts, 64'd333);
    send_frame(anchor_ts + lead_cur, TimeMax);
    send_beat(OP_VIDEO, anchor_ts + lead_cur + 1, 64'd2);
    send_beat(OP_AUDIO_END, anchor_ts - 10, '0);
    audio_cur = anchor_ts + 2 * lead_cur;
    send_beat(OP_AUDIO_END, audio_cur, '0);
    send_frame(anchor_ts + lead_cur + 1, 64'd2);
    send_beat(OP_VIDEO, anchor_ts + 5, 64'd9);
    send_beat(OP_VIDEO, TimeMax, 64'd4);
    send_beat(OP_AUDIO_END, audio_cur, '0);
    send_frame(audio_cur + lead_cur, 64'd417083);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       write_lead('0);
        1:       write_lead('1);
        2:       write_lead($urandom_range(1, 5000));
        3:       write_lead(LeadReset);
        default: write_lead($urandom);
      endcase
      repeat (PhaseBeats) random_beat();
      settle();
    end

    // Audio end near the top of the range: the lead limit saturates.
    write_lead('1);
    audio_cur = TimeMax - $urandom_range(0, 1000);
    send_beat(OP_AUDIO_END, audio_cur, rand_dur());
    repeat (20) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(OP_VIDEO, frame_cur + 1 + $urandom_range(0, 1000), '0);
      end else begin
        send_frame(frame_cur + 1 + $urandom_range(0, 32'h4000_0000), rand_dur());
      end
    end
    send_frame(TimeMax, TimeMax);
    send_beat(OP_VIDEO, TimeMax, 64'd1);
    send_beat(OP_VIDEO, TimeMax - 1, 64'd5);
    settle();
    repeat (4) @(posedge clk_i);

    $display("offered %0d beats under %0d lead settings after reset", beats_sent,
             lead_writes + 1);
    $display("checked %0d result beats, dispositions seen (high to low): %b", verdicts,
             disp_seen);
    if (fail_count == 0) begin
      $display("av_sync_video_frame_gate: match");
    end else begin
      $display("av_sync_video_frame_gate: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/avsfg_pkg.sv
rtl/avsfg_in_stage.sv
rtl/avsfg_core.sv
rtl/avsfg_out_stage.sv
rtl/av_sync_video_frame_gate.sv
rtl/avsfg_checker.sv
tb/gate_verdict_checker.sv
tb/tb_top.sv
